/* rtl/qrm_pkg.sv */
// Package for the quaternion to rotation matrix pipeline.
// Holds the channel word types, the division stage word and fixed widths.
// No dependencies.
package qrm_pkg;

    // Numerator magnitude, denominator and quotient widths
    localparam int NUM_W   = 34;
    localparam int DEN_W   = 33;
    localparam int QUO_W   = 16;
    localparam int LANES   = 9;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 35;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic               zero_norm;
    } mat_out_t;

    // Word carried through the bit-serial division stages
    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] rem;
        logic [LANES-1:0][QUO_W-1:0] quo;
        logic [LANES-1:0]            neg;
        logic [DEN_W-1:0]            den;
        logic                        zero_norm;
    } div_word_t;

endpackage

/* rtl/qrm_front.sv */
// Front end: squares and cross products, then the norm and nine numerators.
// Depends on qrm_pkg.
module qrm_front (
    input  logic                aclk,
    input  logic [1:0]          en,
    input  qrm_pkg::quat_in_t   in_word,
    output qrm_pkg::div_word_t  out_word
);
    import qrm_pkg::*;

    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [SUM_W-1:0]  e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    logic signed [SUM_W-1:0]  num [LANES];
    logic signed [SUM_W-1:0]  abs_v;
    logic [DEN_W-1:0]         den_next;
    div_word_t                out_reg, out_next;

    // Stage one: all ten products
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ww_reg <= in_word.quat_w * in_word.quat_w;
            xx_reg <= in_word.quat_x * in_word.quat_x;
            yy_reg <= in_word.quat_y * in_word.quat_y;
            zz_reg <= in_word.quat_z * in_word.quat_z;
            xy_reg <= in_word.quat_x * in_word.quat_y;
            xz_reg <= in_word.quat_x * in_word.quat_z;
            yz_reg <= in_word.quat_y * in_word.quat_z;
            wx_reg <= in_word.quat_w * in_word.quat_x;
            wy_reg <= in_word.quat_w * in_word.quat_y;
            wz_reg <= in_word.quat_w * in_word.quat_z;
        end
    end

    assign e_ww = SUM_W'(ww_reg);
    assign e_xx = SUM_W'(xx_reg);
    assign e_yy = SUM_W'(yy_reg);
    assign e_zz = SUM_W'(zz_reg);
    assign e_xy = SUM_W'(xy_reg);
    assign e_xz = SUM_W'(xz_reg);
    assign e_yz = SUM_W'(yz_reg);
    assign e_wx = SUM_W'(wx_reg);
    assign e_wy = SUM_W'(wy_reg);
    assign e_wz = SUM_W'(wz_reg);

    // Stage two: norm, numerators, sign and magnitude
    always_comb begin
        num[0] = e_ww + e_xx - e_yy - e_zz;
        num[1] = (e_xy - e_wz) <<< 1;
        num[2] = (e_xz + e_wy) <<< 1;
        num[3] = (e_xy + e_wz) <<< 1;
        num[4] = e_ww - e_xx + e_yy - e_zz;
        num[5] = (e_yz - e_wx) <<< 1;
        num[6] = (e_xz - e_wy) <<< 1;
        num[7] = (e_yz + e_wx) <<< 1;
        num[8] = e_ww - e_xx - e_yy + e_zz;
        den_next = DEN_W'($unsigned(ww_reg)) + DEN_W'($unsigned(xx_reg))
                 + DEN_W'($unsigned(yy_reg)) + DEN_W'($unsigned(zz_reg));
        out_next = '0;
        for (int i = 0; i < LANES; i++) begin
            abs_v = num[i][SUM_W-1] ? -num[i] : num[i];
            out_next.rem[i] = abs_v[NUM_W-1:0];
            out_next.neg[i] = num[i][SUM_W-1];
        end
        out_next.den = den_next;
        out_next.zero_norm = (den_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            out_reg <= out_next;
        end
    end

    assign out_word = out_reg;

endmodule

/* rtl/qrm_div_step.sv */
// One restoring division step: one quotient bit for each of the nine lanes.
// Depends on qrm_pkg.
module qrm_div_step (
    input  logic               aclk,
    input  logic               en,
    input  qrm_pkg::div_word_t in_word,
    output qrm_pkg::div_word_t out_word
);
    import qrm_pkg::*;

    div_word_t        out_reg, out_next;
    logic [NUM_W-1:0] diff;
    logic             take;

    // Trial subtract, shift in the bit, double the remainder
    always_comb begin
        out_next = in_word;
        for (int i = 0; i < LANES; i++) begin
            take = (in_word.rem[i] >= NUM_W'(in_word.den));
            diff = in_word.rem[i] - NUM_W'(in_word.den);
            out_next.quo[i] = {in_word.quo[i][QUO_W-2:0], take};
            out_next.rem[i] = take ? {diff[NUM_W-2:0], 1'b0}
                                   : {in_word.rem[i][NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_word = out_reg;

endmodule

/* rtl/qrm_back.sv */
// Back end: halve-and-round the quotients, apply signs, substitute identity.
// Depends on qrm_pkg.
module qrm_back (
    input  logic               aclk,
    input  logic               en,
    input  qrm_pkg::div_word_t in_word,
    output qrm_pkg::mat_out_t  out_word
);
    import qrm_pkg::*;

    logic signed [LANES-1:0][15:0] el;
    logic [QUO_W:0]                rnd;
    logic [15:0]                   q;
    mat_out_t                      out_reg, out_next;

    // Round to nearest, ties away from zero, from the doubled quotient
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            rnd = {1'b0, in_word.quo[i]} + 17'd1;
            q = rnd[QUO_W:1];
            el[i] = in_word.neg[i] ? -$signed(q) : $signed(q);
        end
        if (in_word.zero_norm) begin
            el = '0;
            el[0] = ONE_Q14;
            el[4] = ONE_Q14;
            el[8] = ONE_Q14;
        end
        out_next = '{m00: el[0], m01: el[1], m02: el[2],
                     m10: el[3], m11: el[4], m12: el[5],
                     m20: el[6], m21: el[7], m22: el[8],
                     zero_norm: in_word.zero_norm};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_word = out_reg;

endmodule

/* rtl/quaternion_to_rotation_matrix.sv */
// Top level of the quaternion to rotation matrix pipeline.
// Depends on qrm_pkg, qrm_front, qrm_div_step and qrm_back.
//
//  channel | ports                    | word
//  --------+--------------------------+------------------------------
//  input   | s_valid s_ready s_data   | quat_in_t: w, x, y, z
//  result  | m_valid m_ready m_data   | mat_out_t: m00..m22, zero_norm
//
// One word per cycle while m_ready stays high; stages: products, sums, 16 division steps, rounding.
// The sixteen one-bit division steps for the nine lanes set the depth.
// Reset clears the stage valid bits only.
// Each stage holds while the one after it is full and held; bubbles are squeezed out.
module quaternion_to_rotation_matrix (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qrm_pkg::quat_in_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output qrm_pkg::mat_out_t m_data
);
    import qrm_pkg::*;

    localparam int NST = QUO_W + 3;

    logic [NST-1:0] v_reg, v_next;
    logic [NST-1:0] en;
    div_word_t      dw [QUO_W+1];

    // Stage enables: load when empty or when the next stage moves
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end
    assign en[NST-1] = !v_reg[NST-1] || m_ready;

    // Advance valid bits with the data
    always_comb begin
        v_next = v_reg;
        if (en[0]) begin
            v_next[0] = s_valid;
        end
        for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    qrm_front u_front (
        .aclk     (aclk),
        .en       (en[1:0]),
        .in_word  (s_data),
        .out_word (dw[0])
    );

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        qrm_div_step u_step (
            .aclk     (aclk),
            .en       (en[j+2]),
            .in_word  (dw[j]),
            .out_word (dw[j+1])
        );
    end

    qrm_back u_back (
        .aclk     (aclk),
        .en       (en[NST-1]),
        .in_word  (dw[QUO_W]),
        .out_word (m_data)
    );

    assign s_ready = en[0];
    assign m_valid = v_reg[NST-1];

`ifndef SYNTHESIS
    a_fill_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NST-2] && !v_reg[NST-1] |=> v_reg[NST-1])
        else $error("word before an empty output stage was not moved on");

    a_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_norm |->
            m_data.m00 == ONE_Q14 && m_data.m11 == ONE_Q14 && m_data.m22 == ONE_Q14
            && m_data.m01 == '0 && m_data.m12 == '0 && m_data.m20 == '0)
        else $error("zero quaternion did not give the identity matrix");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.m00 <= ONE_Q14 && m_data.m00 >= -ONE_Q14
                 && m_data.m11 <= ONE_Q14 && m_data.m11 >= -ONE_Q14)
        else $error("diagonal element out of range");
`endif

endmodule
